// ----- rtl/core/sfbt_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfbt_pkg
// Shared types and constants of the sensor frame biphase transmitter.
// ----------------------------------------------------------------------------
package sfbt_pkg;

    // Item function codes
    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_TICK = 1'b1;

    // Frame layout
    localparam int          FRAME_BITS   = 36;
    localparam logic [3:0]  SYNC_HEAD    = 4'b1100;
    localparam logic [2:0]  SYNC_MID     = 3'b110;
    localparam logic [15:0] TEMP_OFFSET  = 16'd6400;

    // Half-bit sequencing: 72 frame halves, 3 trailer halves, 2 hold halves
    localparam logic [6:0]  FRAME_HALVES = 7'd72;
    localparam logic [6:0]  SENT_HALVES  = 7'd75;
    localparam logic [6:0]  LAST_HOLD    = 7'd76;

    localparam logic [15:0] PERIOD_RESET = 16'd900;

    // id / 10 as (id * 205) >> 11, exact for 8-bit ids
    localparam logic [7:0]  DIV10_MUL    = 8'd205;
    localparam int          DIV10_SHIFT  = 11;

    typedef logic [FRAME_BITS-1:0] t_frame;

    typedef struct packed {
        logic        func;
        logic [7:0]  sensor_id;
        logic [6:0]  humidity;
        logic [15:0] temp_q7;
    } t_item;

    typedef struct packed {
        logic line_level;
        logic busy_res;
        logic frame_done;
    } t_result;

    // Per-beat control into the sequencer
    typedef struct packed {
        logic fire;
        logic func;
    } t_seq_step;

endpackage

// ----- rtl/core/sfbt_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfbt_in_if / sfbt_out_if
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface sfbt_in_if;
    logic               valid;
    logic               ready;
    logic               func;
    logic        [7:0]  sensor_id;
    logic        [6:0]  humidity;
    logic signed [15:0] temp_q7;

    modport source (output valid, func, sensor_id, humidity, temp_q7, input ready);
    modport sink   (input valid, func, sensor_id, humidity, temp_q7, output ready);
endinterface

interface sfbt_out_if;
    logic valid;
    logic ready;
    logic line_level;
    logic busy_res;
    logic frame_done;

    modport source (output valid, line_level, busy_res, frame_done, input ready);
    modport sink   (input valid, line_level, busy_res, frame_done, output ready);
endinterface

// ----- rtl/core/sfbt_frame_build.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfbt_frame_build
// Assembles the 36-bit sensor frame with even parity from one reading.
// ----------------------------------------------------------------------------
module sfbt_frame_build (
    input  sfbt_pkg::t_item  i_item,
    output sfbt_pkg::t_frame o_frame
);
    import sfbt_pkg::*;

    logic [15:0] w_prod;
    logic [4:0]  w_tens;
    logic [7:0]  w_tens_x10;
    logic [3:0]  w_units;
    logic [1:0]  w_chan;
    logic [15:0] w_tsum;
    logic [FRAME_BITS-2:0] w_body;

    // tens digit by reciprocal multiply, units by subtract
    assign w_prod     = 16'(i_item.sensor_id) * 16'(DIV10_MUL);
    assign w_tens     = w_prod[15:DIV10_SHIFT];
    assign w_tens_x10 = 8'(w_tens) * 8'd10;
    assign w_units    = 4'(i_item.sensor_id - w_tens_x10);
    assign w_chan     = w_units[1:0] + 2'd3;   // (units - 1) mod 4

    assign w_tsum = i_item.temp_q7 + TEMP_OFFSET;

    assign w_body  = {SYNC_HEAD, w_tens[3:0], w_chan, SYNC_MID,
                      i_item.humidity, w_tsum[14:0]};
    assign o_frame = {w_body, ^w_body};

endmodule

// ----- rtl/core/sfbt_line_seq.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfbt_line_seq
// Half-bit timer, biphase mark coder and frame/trailer/hold sequencing.
// ----------------------------------------------------------------------------
module sfbt_line_seq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  sfbt_pkg::t_seq_step i_step,
    input  sfbt_pkg::t_frame  i_frame,
    input  logic [15:0]       i_half_period,
    output sfbt_pkg::t_result o_res_next
);
    import sfbt_pkg::*;

    t_frame      r_frame,    n_frame;
    logic [6:0]  r_idx,      n_idx;
    logic [15:0] r_tick_cnt, n_tick_cnt;
    logic        r_level,    n_level;
    logic        r_sending,  n_sending;
    logic        w_done;

    logic        w_tick_wrap;
    logic [5:0]  w_bit_pos;
    logic        w_cur_bit;

    assign w_tick_wrap = ({1'b0, r_tick_cnt} + 17'd1) >= {1'b0, i_half_period};
    assign w_bit_pos   = 6'(FRAME_BITS - 1) - r_idx[6:1];
    // trailer halves read as zero bits
    assign w_cur_bit   = (r_idx < FRAME_HALVES) ? r_frame[w_bit_pos] : 1'b0;

    always_comb begin
        n_frame    = r_frame;
        n_idx      = r_idx;
        n_tick_cnt = r_tick_cnt;
        n_level    = r_level;
        n_sending  = r_sending;
        w_done     = 1'b0;
        if (i_step.fire) begin
            if (i_step.func == FUNC_LOAD) begin
                if (!r_sending) begin
                    n_frame    = i_frame;
                    n_idx      = '0;
                    n_tick_cnt = '0;
                    n_sending  = 1'b1;
                end
            end else if (r_sending) begin
                if (w_tick_wrap) begin
                    n_tick_cnt = '0;
                    if (r_idx < SENT_HALVES) begin
                        // toggle at bit start, and mid-bit for a one
                        if (w_cur_bit || !r_idx[0]) begin
                            n_level = !r_level;
                        end
                        n_idx = r_idx + 7'd1;
                    end else if (r_idx < LAST_HOLD) begin
                        n_idx = r_idx + 7'd1;
                    end else begin
                        n_level   = 1'b0;
                        n_sending = 1'b0;
                        n_idx     = '0;
                        w_done    = 1'b1;
                    end
                end else begin
                    n_tick_cnt = r_tick_cnt + 16'd1;
                end
            end
        end
    end

    assign o_res_next.line_level = n_level;
    assign o_res_next.busy_res   = n_sending;
    assign o_res_next.frame_done = w_done;

    always_ff @(posedge i_clk) begin
        r_frame <= n_frame;
        if (!i_rst_n) begin
            r_idx      <= '0;
            r_tick_cnt <= '0;
            r_level    <= 1'b0;
            r_sending  <= 1'b0;
        end else begin
            r_idx      <= n_idx;
            r_tick_cnt <= n_tick_cnt;
            r_level    <= n_level;
            r_sending  <= n_sending;
        end
    end

    // Idle means line low with counters parked
    a_idle_parked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_sending |-> (!r_level && r_idx == '0 && r_tick_cnt == '0))
        else $error("idle with live sequencer state");

    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx <= LAST_HOLD)
        else $error("half-bit index past end of hold");

    a_done_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done |=> (!r_sending && !r_level))
        else $error("frame done without returning to idle");

    a_done_from_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done |-> (r_sending && r_idx == LAST_HOLD && i_step.func == FUNC_TICK))
        else $error("frame done outside final hold half-bit");

endmodule

// ----- rtl/core/sensor_frame_biphase_transmitter.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sensor_frame_biphase_transmitter
// Sensor frame builder and biphase mark line coder, one result per beat.
// ----------------------------------------------------------------------------
// Usage:
//   i_item carries input beats. func = load builds a 36-bit frame from
//   sensor_id / humidity / temp_q7 and starts sending; func = tick is one
//   microsecond of timebase. Loads arriving while busy are dropped (the
//   beat still yields a result). Every input beat yields exactly one
//   result beat on o_result: line level after that beat, busy flag, and
//   frame_done on the beat where the line returns low after the hold.
//   i_cfg_wr_en / i_cfg_wr_data write the half-bit period in ticks
//   (reset 900); write only while idle.
// Pipeline and throughput:
//   An input beat lands in the input register; when it advances, the
//   sequencer state and the result register are written from it. One
//   beat per cycle sustained while o_result is ready; the per-beat path
//   is the frame build (8x8 multiply, parity) into the sequencer update.
// Stall / reset:
//   When o_result is stalled the result and input registers hold and
//   i_item.ready drops once both are full; nothing is lost. Reset is
//   synchronous active low: line low, idle, period back to 900.
// ----------------------------------------------------------------------------
module sensor_frame_biphase_transmitter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sfbt_in_if.sink     i_item,
    sfbt_out_if.source  o_result,
    input  logic        i_cfg_wr_en,
    input  logic [15:0] i_cfg_wr_data
);
    import sfbt_pkg::*;

    // Input register stage
    t_item   r_in;
    logic    r_in_valid;
    // Result register stage
    t_result r_out;
    logic    r_out_valid;
    // Half-bit period register
    logic [15:0] r_half_period;

    logic      w_in_fire;
    logic      w_advance;
    t_item     w_item;
    t_frame    w_frame;
    t_seq_step w_step;
    t_result   w_res_next;

    // Move the held beat forward when the result slot frees up
    assign w_advance    = r_in_valid && (!r_out_valid || o_result.ready);
    assign i_item.ready = !r_in_valid || w_advance;
    assign w_in_fire    = i_item.valid && i_item.ready;

    assign w_item.func      = i_item.func;
    assign w_item.sensor_id = i_item.sensor_id;
    assign w_item.humidity  = i_item.humidity;
    assign w_item.temp_q7   = i_item.temp_q7;

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_in <= w_item;
        end
        if (w_advance) begin
            r_out <= w_res_next;
        end
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_half_period <= PERIOD_RESET;
        end else begin
            if (w_in_fire) begin
                r_in_valid <= 1'b1;
            end else if (w_advance) begin
                r_in_valid <= 1'b0;
            end
            if (w_advance) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_wr_en) begin
                r_half_period <= i_cfg_wr_data;
            end
        end
    end

    sfbt_frame_build u_frame_build (
        .i_item  (r_in),
        .o_frame (w_frame)
    );

    assign w_step.fire = w_advance;
    assign w_step.func = r_in.func;

    sfbt_line_seq u_line_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (w_step),
        .i_frame       (w_frame),
        .i_half_period (r_half_period),
        .o_res_next    (w_res_next)
    );

    assign o_result.valid      = r_out_valid;
    assign o_result.line_level = r_out.line_level;
    assign o_result.busy_res   = r_out.busy_res;
    assign o_result.frame_done = r_out.frame_done;

endmodule
